>>> rtl/pmwq_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the priority mutex wait queue.
package pmwq_pkg;

    localparam int MAX_TASKS   = 16;
    localparam int PRIO_LEVELS = 256;
    localparam int QDEPTH      = MAX_TASKS - 1;

    localparam int TASK_W   = 4;
    localparam int PRIO_W   = 8;
    localparam int COUNT_W  = 4;
    localparam int STATUS_W = 3;

    // Task numbers wrap at MAX_TASKS, which is a power of two.
    localparam logic [TASK_W-1:0] TASK_MASK = TASK_W'(MAX_TASKS - 1);
    localparam logic [PRIO_W-1:0] PRIO_MAX  = PRIO_W'(PRIO_LEVELS - 1);
    localparam logic [COUNT_W-1:0] QFULL    = COUNT_W'(QDEPTH);

    typedef enum logic {
        CMD_WAIT = 1'b0,
        CMD_POST = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACQUIRED  = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_RELEASED  = 3'd2,
        ST_HANDED    = 3'd3,
        ST_NOT_OWNER = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic exec;
    } pmwq_cmd_t;

endpackage

>>> rtl/pmwq_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: input capture, execution slot and result valid.
module pmwq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output pmwq_pkg::pmwq_cmd_t cmd
);

    pmwq_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pmwq_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        s_ready      = 1'b0;
        cmd.load_in  = 1'b0;
        cmd.exec     = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            pmwq_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = pmwq_pkg::S_EXEC;
                end
            end
            pmwq_pkg::S_EXEC: begin
                // Commit only when the output register is empty or is being taken this cycle.
                if (!m_valid_reg || m_ready) begin
                    cmd.exec     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = pmwq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = pmwq_pkg::S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

>>> rtl/pmwq_dp.sv
`timescale 1ns / 1ps
// Datapath: owner registers, the insert and shift cell row of waiters, result register.
module pmwq_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  pmwq_pkg::pmwq_cmd_t             cmd,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    input  logic                            s_cmd,
    input  logic [pmwq_pkg::TASK_W-1:0]     s_task_req,
    input  logic [pmwq_pkg::PRIO_W-1:0]     s_prio,
    output logic [pmwq_pkg::STATUS_W-1:0]   m_status,
    output logic                            m_owner_valid,
    output logic [pmwq_pkg::TASK_W-1:0]     m_owner_task,
    output logic [pmwq_pkg::PRIO_W-1:0]     m_owner_prio,
    output logic                            m_boosted,
    output logic [pmwq_pkg::PRIO_W-1:0]     m_restored_prio,
    output logic [pmwq_pkg::COUNT_W-1:0]    m_waiting
);

    localparam int QD = pmwq_pkg::QDEPTH;
    localparam int TW = pmwq_pkg::TASK_W;
    localparam int PW = pmwq_pkg::PRIO_W;
    localparam int CW = pmwq_pkg::COUNT_W;

    // Captured request.
    pmwq_pkg::cmd_t cmd_in_reg;
    logic [TW-1:0]  task_in_reg;
    logic [PW-1:0]  prio_in_reg;

    logic inherit_reg;

    // Mutex state.
    logic          owned_reg, owned_next;
    logic [TW-1:0] holder_reg, holder_next;
    logic [PW-1:0] hprio_reg, hprio_next;
    logic [PW-1:0] horig_reg, horig_next;
    logic          hboost_reg, hboost_next;
    logic [CW-1:0] q_len_reg, q_len_next;

    // Waiter row; entries at or beyond q_len_reg are never read.
    logic [TW-1:0] q_task_reg [QD];
    logic [PW-1:0] q_prio_reg [QD];

    pmwq_pkg::status_t status_next;
    logic              boost_next;
    logic [PW-1:0]     restored_next;
    logic              do_insert, do_pop;
    logic [CW-1:0]     ins_pos, scan_pos;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_in_reg  <= pmwq_pkg::cmd_t'(s_cmd);
            task_in_reg <= s_task_req & pmwq_pkg::TASK_MASK;
            prio_in_reg <= (s_prio > pmwq_pkg::PRIO_MAX) ? pmwq_pkg::PRIO_MAX : s_prio;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inherit_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            inherit_reg <= cfg_wr_data;
        end
    end

    // First waiter that is strictly worse than the request, else the tail.
    always_comb begin
        scan_pos = q_len_reg;
        for (int i = QD - 1; i >= 0; i--) begin
            if ((CW'(i) < q_len_reg) && (q_prio_reg[i] > prio_in_reg)) begin
                scan_pos = CW'(i);
            end
        end
    end

    always_comb begin
        owned_next    = owned_reg;
        holder_next   = holder_reg;
        hprio_next    = hprio_reg;
        horig_next    = horig_reg;
        hboost_next   = hboost_reg;
        q_len_next    = q_len_reg;
        status_next   = pmwq_pkg::ST_NOT_OWNER;
        boost_next    = 1'b0;
        restored_next = '0;
        do_insert     = 1'b0;
        do_pop        = 1'b0;
        ins_pos       = scan_pos;
        if (cmd_in_reg == pmwq_pkg::CMD_WAIT) begin
            if (!owned_reg) begin
                owned_next  = 1'b1;
                holder_next = task_in_reg;
                hprio_next  = prio_in_reg;
                horig_next  = prio_in_reg;
                hboost_next = 1'b0;
                status_next = pmwq_pkg::ST_ACQUIRED;
            end else if (q_len_reg >= pmwq_pkg::QFULL) begin
                status_next = pmwq_pkg::ST_FULL;
            end else begin
                do_insert   = 1'b1;
                q_len_next  = q_len_reg + 1'b1;
                status_next = pmwq_pkg::ST_QUEUED;
                if (hprio_reg > prio_in_reg) begin
                    ins_pos = '0;
                    if (inherit_reg) begin
                        if (!hboost_reg) begin
                            horig_next  = hprio_reg;
                            hboost_next = 1'b1;
                        end
                        hprio_next = prio_in_reg;
                        boost_next = 1'b1;
                    end
                end
            end
        end else begin
            if (owned_reg && (holder_reg == task_in_reg)) begin
                restored_next = horig_reg;
                hboost_next   = 1'b0;
                if (q_len_reg == '0) begin
                    owned_next  = 1'b0;
                    holder_next = '0;
                    hprio_next  = '0;
                    horig_next  = '0;
                    status_next = pmwq_pkg::ST_RELEASED;
                end else begin
                    holder_next = q_task_reg[0];
                    hprio_next  = q_prio_reg[0];
                    horig_next  = q_prio_reg[0];
                    do_pop      = 1'b1;
                    q_len_next  = q_len_reg - 1'b1;
                    status_next = pmwq_pkg::ST_HANDED;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owned_reg  <= 1'b0;
            holder_reg <= '0;
            hprio_reg  <= '0;
            horig_reg  <= '0;
            hboost_reg <= 1'b0;
            q_len_reg  <= '0;
        end else if (cmd.exec) begin
            owned_reg  <= owned_next;
            holder_reg <= holder_next;
            hprio_reg  <= hprio_next;
            horig_reg  <= horig_next;
            hboost_reg <= hboost_next;
            q_len_reg  <= q_len_next;
        end
    end

    // Each cell keeps, takes the new request, or takes its neighbor.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < QD; i++) begin
            if (cmd.exec && do_insert) begin
                if (CW'(i) == ins_pos) begin
                    q_task_reg[i] <= task_in_reg;
                    q_prio_reg[i] <= prio_in_reg;
                end else if ((CW'(i) > ins_pos) && (i > 0)) begin
                    q_task_reg[i] <= q_task_reg[(i > 0) ? i - 1 : 0];
                    q_prio_reg[i] <= q_prio_reg[(i > 0) ? i - 1 : 0];
                end
            end else if (cmd.exec && do_pop && (i < QD - 1)) begin
                q_task_reg[i] <= q_task_reg[(i < QD - 1) ? i + 1 : i];
                q_prio_reg[i] <= q_prio_reg[(i < QD - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            m_status        <= status_next;
            m_owner_valid   <= owned_next;
            m_owner_task    <= owned_next ? holder_next : '0;
            m_owner_prio    <= owned_next ? hprio_next : '0;
            m_boosted       <= boost_next;
            m_restored_prio <= restored_next;
            m_waiting       <= q_len_next;
        end
    end

    // A free mutex never has waiters.
    a_free_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !owned_reg |-> (q_len_reg == '0))
        else $error("waiters present while the mutex is free");

    // A boost is only in force while someone owns the mutex.
    a_boost_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        hboost_reg |-> owned_reg)
        else $error("boost flag set without an owner");

    // A refused wait or post leaves the queue length alone.
    a_refused_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && (status_next == pmwq_pkg::ST_FULL ||
                      status_next == pmwq_pkg::ST_NOT_OWNER))
        |=> (q_len_reg == $past(q_len_reg)))
        else $error("refused request changed the queue");

    // A queued wait grows the queue by exactly one.
    a_queued_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && status_next == pmwq_pkg::ST_QUEUED)
        |=> (q_len_reg == $past(q_len_reg) + 1'b1))
        else $error("queued wait did not add one waiter");

endmodule

>>> rtl/priority_mutex_wait_queue_top.sv
`timescale 1ns / 1ps
// Top level of the priority mutex wait queue: controller and datapath.
//
//  Channel   Direction  Handshake               Word
//  s_        in         s_valid / s_ready       cmd, task_req, prio
//  m_        out        m_valid / m_ready       status, owner and queue snapshot
//  cfg_      in         cfg_wr_en (no wait)     inherit_enable
//
// Each word is first captured, then the mutex and the waiter row are updated and
// the result register is loaded. The row of 15 compare-and-shift cells does a
// whole insertion or removal within that update.
// A new word is taken while the previous result still waits in the output
// register; the update cycle stalls only until that register is taken.
// Reset (aresetn low, synchronous) frees the mutex, empties the queue and sets
// inheritance on; the waiter cells themselves are not cleared.
module priority_mutex_wait_queue_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_cmd,
    input  logic [pmwq_pkg::TASK_W-1:0]     s_task_req,
    input  logic [pmwq_pkg::PRIO_W-1:0]     s_prio,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pmwq_pkg::STATUS_W-1:0]   m_status,
    output logic                            m_owner_valid,
    output logic [pmwq_pkg::TASK_W-1:0]     m_owner_task,
    output logic [pmwq_pkg::PRIO_W-1:0]     m_owner_prio,
    output logic                            m_boosted,
    output logic [pmwq_pkg::PRIO_W-1:0]     m_restored_prio,
    output logic [pmwq_pkg::COUNT_W-1:0]    m_waiting
);

    // Commands from the state machine into the datapath.
    pmwq_pkg::pmwq_cmd_t ctrl_cmd;

    // The controller owns the handshakes and decides when a word commits.
    pmwq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (ctrl_cmd)
    );

    // The datapath holds the owner, the waiter row and the result register.
    pmwq_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (ctrl_cmd),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_cmd           (s_cmd),
        .s_task_req      (s_task_req),
        .s_prio          (s_prio),
        .m_status        (m_status),
        .m_owner_valid   (m_owner_valid),
        .m_owner_task    (m_owner_task),
        .m_owner_prio    (m_owner_prio),
        .m_boosted       (m_boosted),
        .m_restored_prio (m_restored_prio),
        .m_waiting       (m_waiting)
    );

endmodule
